// File: sv/nvidt_pkg.sv
// ----------------------------------------------------------------------------
// NV index descriptor table package
// Shared constants and request/status codes of the descriptor table.
// ----------------------------------------------------------------------------
package nvidt_pkg;

    localparam int unsigned SLOTS_DEF        = 16;
    localparam int unsigned MAX_DATA_DEF     = 2048;
    localparam int unsigned POLICY_BYTES_DEF = 64;
    localparam logic [31:0] HANDLE_FIRST_DEF = 32'h0100_0000;
    localparam logic [31:0] HANDLE_LAST_DEF  = 32'h01FF_FFFF;

    localparam int unsigned TYPE_SHIFT  = 24;
    localparam int unsigned WRITTEN_POS = 29;

    localparam logic [15:0] ALG_SHA1   = 16'h0004;
    localparam logic [15:0] ALG_SHA256 = 16'h000B;
    localparam logic [15:0] ALG_SHA384 = 16'h000C;
    localparam logic [15:0] ALG_SHA512 = 16'h000D;

    localparam logic [2:0] REQ_DEFINE = 3'd0;
    localparam logic [2:0] REQ_WRITE  = 3'd1;
    localparam logic [2:0] REQ_FIND   = 3'd2;
    localparam logic [2:0] REQ_ENUM   = 3'd3;
    localparam logic [2:0] REQ_COUNT  = 3'd4;
    localparam logic [2:0] REQ_CLEAR  = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_HASH      = 3'd2;
    localparam logic [2:0] ST_SIZE      = 3'd3;
    localparam logic [2:0] ST_DEFINED   = 3'd4;
    localparam logic [2:0] ST_NO_SPACE  = 3'd5;
    localparam logic [2:0] ST_UNKNOWN   = 3'd6;
    localparam logic [2:0] ST_TOO_LONG  = 3'd7;

endpackage

// File: sv/nv_index_descriptor_table_core.sv
// ----------------------------------------------------------------------------
// NV index descriptor table core
// Table of non-volatile index descriptors with define, write, find,
// enumerate, count and clear requests.
// ----------------------------------------------------------------------------
// A request is taken as one input item. The block then walks the table with
// one shared slot comparator, one slot per cycle, and is not ready until the
// last result item of that request has been taken. Define, write, find and
// count scan every slot, then form the result and hand it off. Enumerate runs
// one full scan of the table per handle it returns, picking the smallest
// handle above the previous one; its terminator item carries the tally.
// Clear all zeroes the table and registers its result in the cycle in which
// it is accepted. Results leave through an output register; the next request
// is accepted once that register is empty again, and a receiver that stalls
// holds the block back.
module nv_index_descriptor_table_core #(
    parameter int unsigned SLOTS        = nvidt_pkg::SLOTS_DEF,
    parameter int unsigned MAX_DATA     = nvidt_pkg::MAX_DATA_DEF,
    parameter int unsigned POLICY_BYTES = nvidt_pkg::POLICY_BYTES_DEF,
    parameter logic [31:0] HANDLE_FIRST = nvidt_pkg::HANDLE_FIRST_DEF,
    parameter logic [31:0] HANDLE_LAST  = nvidt_pkg::HANDLE_LAST_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[2:0], handle[34:3], name_alg[50:35], attributes[82:51],
    // policy_len[98:83], defined_size[114:99], write_len[130:115],
    // max_count[138:131], zero fill to 144 bits
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], found[3], out_handle[35:4], out_alg[51:36],
    // out_attributes[83:52], out_size[99:84], out_written[115:100],
    // tally[120:116], zero fill to 128 bits
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT, S_OUT} state_t;

    state_t state_reg;
    logic [SLOTS-1:0] used_reg;
    logic [31:0] hnd_mem [SLOTS];
    logic [15:0] alg_mem [SLOTS];
    logic [31:0] attr_mem [SLOTS];
    logic [15:0] size_mem [SLOTS];
    logic [15:0] wr_mem [SLOTS];

    logic [2:0]  req_reg;
    logic [31:0] hin_reg;
    logic [15:0] alg_in_reg;
    logic [31:0] attr_in_reg;
    logic [15:0] wlen_reg;
    logic [7:0]  maxc_reg;
    logic [2:0]  pre_st_reg;   // status of checks done at accept time
    logic [IW-1:0] idx_reg;
    logic        hit_reg, free_ok_reg, best_ok_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg, best_idx_reg;
    logic [31:0] best_h_reg, prev_reg;
    logic [CW-1:0] cnt_reg, n_reg;

    logic [127:0] od_reg;
    logic         ol_reg, ov_reg;

    // request fields
    logic [2:0]  f_req;
    logic [31:0] f_h, f_attr;
    logic [15:0] f_alg, f_plen, f_dsize, f_wlen;
    logic [7:0]  f_maxc;
    assign f_req   = s_axis_tdata[2:0];
    assign f_h     = s_axis_tdata[34:3];
    assign f_alg   = s_axis_tdata[50:35];
    assign f_attr  = s_axis_tdata[82:51];
    assign f_plen  = s_axis_tdata[98:83];
    assign f_dsize = s_axis_tdata[114:99];
    assign f_wlen  = s_axis_tdata[130:115];
    assign f_maxc  = s_axis_tdata[138:131];

    logic [2:0] pre_st;
    always_comb
    begin
        if (f_h < HANDLE_FIRST || f_h > HANDLE_LAST)
            pre_st = nvidt_pkg::ST_RANGE;
        else if (!(f_alg == nvidt_pkg::ALG_SHA1 || f_alg == nvidt_pkg::ALG_SHA256 ||
                   f_alg == nvidt_pkg::ALG_SHA384 || f_alg == nvidt_pkg::ALG_SHA512))
            pre_st = nvidt_pkg::ST_HASH;
        else if (32'(f_plen) > 32'(POLICY_BYTES))
            pre_st = nvidt_pkg::ST_SIZE;
        else if (f_dsize == 16'd0 || 32'(f_dsize) > 32'(MAX_DATA))
            pre_st = nvidt_pkg::ST_SIZE;
        else
            pre_st = nvidt_pkg::ST_OK;
    end

    // shared slot comparator
    logic [31:0] cur_h;
    logic        cur_used, cur_match, cur_cand;
    assign cur_h     = hnd_mem[idx_reg];
    assign cur_used  = used_reg[idx_reg];
    assign cur_match = cur_used && (cur_h == hin_reg);
    assign cur_cand  = cur_used && (cur_h >= hin_reg) && (n_reg == '0 || cur_h > prev_reg)
                       && (!best_ok_reg || cur_h < best_h_reg);

    logic enum_go;
    assign enum_go = (maxc_reg != 8'd0) &&
                     (hin_reg[31:nvidt_pkg::TYPE_SHIFT] ==
                      HANDLE_FIRST[31:nvidt_pkg::TYPE_SHIFT]);

    // The enumerate scan found another handle that may still be returned.
    logic enum_more;
    assign enum_more = (req_reg == nvidt_pkg::REQ_ENUM) && enum_go && best_ok_reg &&
                       (32'(n_reg) < 32'(maxc_reg)) && (32'(n_reg) < 32'(SLOTS));

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;

    function automatic logic [127:0] pack_out(logic [2:0] st, logic fnd, logic [31:0] h,
        logic [15:0] a, logic [31:0] at, logic [15:0] sz, logic [15:0] w, logic [4:0] t);
        return {7'd0, t, w, sz, at, a, h, fnd, st};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            ol_reg    <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                hnd_mem[i]  <= '0;
                alg_mem[i]  <= '0;
                attr_mem[i] <= '0;
                size_mem[i] <= '0;
                wr_mem[i]   <= '0;
            end
        end
        else
        begin
            if (ov_reg && m_axis_tready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        req_reg     <= f_req;
                        hin_reg     <= f_h;
                        alg_in_reg  <= f_alg;
                        attr_in_reg <= f_attr;
                        wlen_reg    <= f_wlen;
                        maxc_reg    <= f_maxc;
                        pre_st_reg  <= pre_st;
                        best_h_reg  <= {16'd0, f_dsize};  // defined size held here
                        idx_reg     <= '0;
                        hit_reg     <= 1'b0;
                        free_ok_reg <= 1'b0;
                        best_ok_reg <= 1'b0;
                        cnt_reg     <= '0;
                        n_reg       <= '0;
                        prev_reg    <= '0;
                        if (f_req == nvidt_pkg::REQ_CLEAR)
                        begin
                            used_reg <= '0;
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                hnd_mem[i]  <= '0;
                                alg_mem[i]  <= '0;
                                attr_mem[i] <= '0;
                                size_mem[i] <= '0;
                                wr_mem[i]   <= '0;
                            end
                            od_reg    <= '0;
                            ol_reg    <= 1'b1;
                            ov_reg    <= 1'b1;
                        end
                        else if (f_req > nvidt_pkg::REQ_CLEAR)
                        begin
                            od_reg <= '0;
                            ol_reg <= 1'b1;
                            ov_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // one slot per cycle through the shared comparator
                    if (req_reg == nvidt_pkg::REQ_ENUM)
                    begin
                        if (cur_cand)
                        begin
                            best_ok_reg  <= 1'b1;
                            best_h_reg   <= cur_h;
                            best_idx_reg <= idx_reg;
                        end
                    end
                    else
                    begin
                        if (cur_match && !hit_reg)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= idx_reg;
                        end
                        if (!cur_used && !free_ok_reg)
                        begin
                            free_ok_reg  <= 1'b1;
                            free_idx_reg <= idx_reg;
                        end
                        if (cur_used)
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_EMIT:
                begin
                    if (!ov_reg)
                    begin
                        ov_reg    <= 1'b1;
                        ol_reg    <= !enum_more;
                        state_reg <= enum_more ? S_OUT : S_IDLE;
                        unique case (req_reg)
                            nvidt_pkg::REQ_DEFINE:
                            begin
                                if (pre_st_reg != nvidt_pkg::ST_OK)
                                    od_reg <= pack_out(pre_st_reg, 1'b0, '0, '0, '0, '0,
                                                       '0, 5'd0);
                                else if (hit_reg)
                                    od_reg <= pack_out(nvidt_pkg::ST_DEFINED, 1'b0, '0, '0,
                                                       '0, '0, '0, 5'd0);
                                else if (!free_ok_reg)
                                    od_reg <= pack_out(nvidt_pkg::ST_NO_SPACE, 1'b0, '0, '0,
                                                       '0, '0, '0, 5'd0);
                                else
                                begin
                                    od_reg <= '0;
                                    used_reg[free_idx_reg] <= 1'b1;
                                    hnd_mem[free_idx_reg]  <= hin_reg;
                                    alg_mem[free_idx_reg]  <= alg_in_reg;
                                    attr_mem[free_idx_reg] <= attr_in_reg &
                                        ~(32'd1 << nvidt_pkg::WRITTEN_POS);
                                    size_mem[free_idx_reg] <= best_h_reg[15:0];
                                    wr_mem[free_idx_reg]   <= '0;
                                end
                            end
                            nvidt_pkg::REQ_WRITE:
                            begin
                                if (!hit_reg)
                                    od_reg <= pack_out(nvidt_pkg::ST_UNKNOWN, 1'b0, '0, '0,
                                                       '0, '0, '0, 5'd0);
                                else if (wlen_reg > size_mem[hit_idx_reg])
                                    od_reg <= pack_out(nvidt_pkg::ST_TOO_LONG, 1'b0, '0, '0,
                                                       '0, '0, '0, 5'd0);
                                else
                                begin
                                    od_reg <= '0;
                                    wr_mem[hit_idx_reg] <= wlen_reg;
                                    attr_mem[hit_idx_reg][nvidt_pkg::WRITTEN_POS] <= 1'b1;
                                end
                            end
                            nvidt_pkg::REQ_FIND:
                            begin
                                if (hit_reg)
                                    od_reg <= pack_out(nvidt_pkg::ST_OK, 1'b1,
                                        hnd_mem[hit_idx_reg], alg_mem[hit_idx_reg],
                                        attr_mem[hit_idx_reg], size_mem[hit_idx_reg],
                                        wr_mem[hit_idx_reg], 5'd0);
                                else
                                    od_reg <= '0;
                            end
                            nvidt_pkg::REQ_COUNT:
                                od_reg <= pack_out(nvidt_pkg::ST_OK, 1'b0, '0, '0, '0, '0,
                                                   '0, 5'(cnt_reg));
                            default:
                            begin
                                // enumerate: one scan per returned handle
                                if (enum_more)
                                begin
                                    od_reg <= pack_out(nvidt_pkg::ST_OK, 1'b0, best_h_reg,
                                                       '0, '0, '0, '0, 5'd0);
                                    prev_reg    <= best_h_reg;
                                    n_reg       <= n_reg + 1'b1;
                                    best_ok_reg <= 1'b0;
                                end
                                else
                                    od_reg <= pack_out(nvidt_pkg::ST_OK, 1'b0, '0, '0, '0,
                                                       '0, '0, 5'(n_reg));
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    // rescan for the next smallest handle, or emit the terminator once the limit is reached
                    state_reg <= (32'(n_reg) < 32'(maxc_reg) && 32'(n_reg) < 32'(SLOTS))
                                 ? S_SCAN : S_EMIT;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
